// ===== hw/rtl/rjus_pkg.sv =====
// Shared types, codes and constants for the join/uplink sequencer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rjus_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DELAY_W   = 31;
  localparam int unsigned CMD_W     = 4;
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;

  // Fixed gaps between set-up commands, and join hold and fail retry times, in ms
  localparam logic [TIME_W-1:0] SHORT_GAP_MS  = 32'd300;
  localparam logic [TIME_W-1:0] LONG_GAP_MS   = 32'd500;
  localparam logic [TIME_W-1:0] JOIN_HOLD_MS  = 32'd10000;
  localparam logic [TIME_W-1:0] FAIL_RETRY_MS = 32'd5000;

  // Register reset values
  localparam logic [DELAY_W-1:0] UPLINK_PERIOD_RST = 31'd60000;
  localparam logic [DELAY_W-1:0] STARTUP_DELAY_RST = 31'd1000;
  localparam logic [DELAY_W-1:0] JOIN_TIMEOUT_RST  = 31'd15000;
  localparam logic [DELAY_W-1:0] JOIN_RETRY_RST    = 31'd5000;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE    = 4'd0,
    CMD_PING    = 4'd1,
    CMD_VERSION = 4'd2,
    CMD_MODE    = 4'd3,
    CMD_REGION  = 4'd4,
    CMD_DEVID   = 4'd5,
    CMD_APPID   = 4'd6,
    CMD_KEY     = 4'd7,
    CMD_JOIN    = 4'd8,
    CMD_UPLINK  = 4'd9
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPLINK_PERIOD = 3'd0,
    REG_STARTUP_DELAY = 3'd1,
    REG_JOIN_TIMEOUT  = 3'd2,
    REG_JOIN_RETRY    = 3'd3,
    REG_HAS_DEVID     = 3'd4,
    REG_HAS_APPID     = 3'd5,
    REG_HAS_APPKEY    = 3'd6
  } cfg_idx_t;

  // Sequencer steps; STEP_DONE means join has been issued
  localparam logic [STEP_W-1:0] STEP_PING    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_VERSION = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MODE    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_REGION  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DEVID   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_APPID   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_KEY     = 4'd6;
  localparam logic [STEP_W-1:0] STEP_JOIN    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DONE    = 4'd8;

  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_START = 1'b1;

  typedef struct packed {
    logic [DELAY_W-1:0] uplink_interval_ms;
    logic [DELAY_W-1:0] boot_delay_ms;
    logic [DELAY_W-1:0] join_timeout_ms;
    logic [DELAY_W-1:0] join_retry_delay_ms;
    logic               has_device_id;
    logic               has_application_id;
    logic               has_application_key;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] now_time;
    logic              join_ok_flag;
    logic              join_fail_flag;
    logic              tx_ready;
  } item_t;

  typedef struct packed {
    logic              armed;
    logic [STEP_W-1:0] step_number;
    logic              joined_state;
    logic [TIME_W-1:0] next_action_time;
    logic [TIME_W-1:0] join_deadline_time;
    logic [TIME_W-1:0] last_uplink_time;
  } seq_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rjus_item_if.sv =====
// Input item channel: valid/ready handshake and the item fields.
// Depends on rjus_pkg for field widths.
`default_nettype none

interface rjus_item_if
  import rjus_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [TIME_W-1:0] now_time;
  logic              join_ok_flag;
  logic              join_fail_flag;
  logic              tx_ready;

  modport source (output valid, func, now_time, join_ok_flag, join_fail_flag, tx_ready,
                  input ready);
  modport sink   (input valid, func, now_time, join_ok_flag, join_fail_flag, tx_ready,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rjus_result_if.sv =====
// Result channel: valid/ready handshake and the result fields.
// Depends on rjus_pkg for field widths.
`default_nettype none

interface rjus_result_if
  import rjus_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic              is_joined;
  logic [STEP_W-1:0] current_step;
  logic              active;

  modport source (output valid, command, is_joined, current_step, active, input ready);
  modport sink   (input valid, command, is_joined, current_step, active, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rjus_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on rjus_pkg for widths.
`default_nettype none

interface rjus_cfg_if
  import rjus_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DELAY_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rjus_cfg_regs.sv =====
// Configuration register file for the sequencer.
// Depends on rjus_pkg and rjus_cfg_if.
`default_nettype none

module rjus_cfg_regs
  import rjus_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  rjus_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.uplink_interval_ms  <= UPLINK_PERIOD_RST;
      regs.boot_delay_ms       <= STARTUP_DELAY_RST;
      regs.join_timeout_ms     <= JOIN_TIMEOUT_RST;
      regs.join_retry_delay_ms <= JOIN_RETRY_RST;
      regs.has_device_id       <= 1'b0;
      regs.has_application_id  <= 1'b0;
      regs.has_application_key <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg_idx_t'(cfg.index))
        REG_UPLINK_PERIOD: regs.uplink_interval_ms  <= cfg.data;
        REG_STARTUP_DELAY: regs.boot_delay_ms       <= cfg.data;
        REG_JOIN_TIMEOUT:  regs.join_timeout_ms     <= cfg.data;
        REG_JOIN_RETRY:    regs.join_retry_delay_ms <= cfg.data;
        REG_HAS_DEVID:     regs.has_device_id       <= cfg.data[0];
        REG_HAS_APPID:     regs.has_application_id  <= cfg.data[0];
        REG_HAS_APPKEY:    regs.has_application_key <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rjus_step.sv =====
// Next-state and command logic for one item: start, overrides, set-up step, uplink.
// Purely combinational. Depends on rjus_pkg.
`default_nettype none

module rjus_step
  import rjus_pkg::*;
(
  input  wire seq_state_t cur,
  input  wire item_t      item,
  input  wire cfg_t       regs,
  output seq_state_t      nxt,
  output cmd_t            cmd
);

  logic [TIME_W-1:0] now;
  logic              wd_fire;
  logic              base_due;
  logic              due;
  logic [TIME_W-1:0] since_uplink;

  // Wrap-safe: deadline passed when (now - deadline) has its top bit clear
  function automatic logic time_reached(input logic [TIME_W-1:0] t,
                                        input logic [TIME_W-1:0] deadline);
    logic [TIME_W-1:0] diff;
    diff = t - deadline;
    return ~diff[TIME_W-1];
  endfunction

  assign now          = item.now_time;
  assign base_due     = time_reached(now, cur.next_action_time);
  assign since_uplink = now - cur.last_uplink_time;
  assign wd_fire      = (cur.step_number == STEP_DONE) && !cur.joined_state &&
                        (cur.join_deadline_time != '0) &&
                        time_reached(now, cur.join_deadline_time);

  always_comb begin
    nxt = cur;
    cmd = CMD_NONE;
    due = base_due;
    if (item.func == FUNC_START) begin
      nxt.armed            = 1'b1;
      nxt.next_action_time = now + {1'b0, regs.boot_delay_ms};
      nxt.last_uplink_time = '0;
      nxt.step_number      = STEP_PING;
      nxt.joined_state     = 1'b0;
    end else if (cur.armed) begin
      // A fresh deadline now+d has passed only when d is zero
      if (wd_fire) begin
        nxt.join_deadline_time = '0;
        nxt.step_number        = STEP_JOIN;
        nxt.next_action_time   = now + {1'b0, regs.join_retry_delay_ms};
        due                    = (regs.join_retry_delay_ms == '0);
      end
      if (item.join_fail_flag && !item.join_ok_flag) begin
        nxt.joined_state       = 1'b0;
        nxt.join_deadline_time = '0;
        nxt.step_number        = STEP_JOIN;
        nxt.next_action_time   = now + FAIL_RETRY_MS;
        due                    = 1'b0;
      end
      if (item.join_ok_flag) begin
        nxt.joined_state       = 1'b1;
        nxt.join_deadline_time = '0;
        nxt.step_number        = STEP_DONE;
      end

      if (item.tx_ready && due) begin
        unique case (nxt.step_number)
          STEP_PING: begin
            cmd = CMD_PING;
            nxt.step_number      = STEP_VERSION;
            nxt.next_action_time = now + SHORT_GAP_MS;
          end
          STEP_VERSION: begin
            cmd = CMD_VERSION;
            nxt.step_number      = STEP_MODE;
            nxt.next_action_time = now + SHORT_GAP_MS;
          end
          STEP_MODE: begin
            cmd = CMD_MODE;
            nxt.step_number      = STEP_REGION;
            nxt.next_action_time = now + SHORT_GAP_MS;
          end
          STEP_REGION: begin
            cmd = CMD_REGION;
            priority if (regs.has_device_id)       nxt.step_number = STEP_DEVID;
            else if (regs.has_application_id)      nxt.step_number = STEP_APPID;
            else if (regs.has_application_key)     nxt.step_number = STEP_KEY;
            else                                   nxt.step_number = STEP_JOIN;
            nxt.next_action_time = now + LONG_GAP_MS;
          end
          STEP_DEVID: begin
            cmd = CMD_DEVID;
            priority if (regs.has_application_id)  nxt.step_number = STEP_APPID;
            else if (regs.has_application_key)     nxt.step_number = STEP_KEY;
            else                                   nxt.step_number = STEP_JOIN;
            nxt.next_action_time = now + LONG_GAP_MS;
          end
          STEP_APPID: begin
            cmd = CMD_APPID;
            nxt.step_number      = regs.has_application_key ? STEP_KEY : STEP_JOIN;
            nxt.next_action_time = now + LONG_GAP_MS;
          end
          STEP_KEY: begin
            cmd = CMD_KEY;
            nxt.step_number      = STEP_JOIN;
            nxt.next_action_time = now + LONG_GAP_MS;
          end
          STEP_JOIN: begin
            cmd = CMD_JOIN;
            nxt.step_number        = STEP_DONE;
            nxt.next_action_time   = now + JOIN_HOLD_MS;
            nxt.join_deadline_time = now + {1'b0, regs.join_timeout_ms};
          end
          default: ;
        endcase
      end

      // Only one command per tick: a set-up command blocks the uplink
      if (nxt.joined_state && item.tx_ready && (cmd == CMD_NONE) &&
          (since_uplink >= {1'b0, regs.uplink_interval_ms})) begin
        cmd = CMD_UPLINK;
        nxt.last_uplink_time = now;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/radio_join_uplink_sequencer.sv =====
// Join/uplink sequencer for a radio modem: input register, step logic, result register.
// Depends on rjus_pkg, the three channel interfaces, rjus_cfg_regs and rjus_step.
//
// Usage:
//   item   - valid/ready input channel. func=1 (start) arms the sequencer and
//            schedules the first set-up command after the boot delay; func=0
//            (tick) carries the ms time, the parser's join flags and tx_ready.
//   result - valid/ready output channel, exactly one transfer per item: the
//            command to issue (0 = none) plus joined, step and armed status
//            after the item.
//   cfg    - write-only register channel, always ready; write while idle.
// Datapath: an item transfer loads the input register; the result register then
//   loads from the combinational step logic once the result channel is free.
// Throughput: one item per cycle unless result stalls; sequencer state is updated
//   in the same cycle the result register loads, so the next item sees it at once.
// Reset: synchronous rst clears the sequencer state (disarmed, step 0, not
//   joined, all times 0), empties both stages and restores register defaults.
// Stall: while result is held, one more item is taken into the input register,
//   then item.ready drops until the result transfers.
`default_nettype none

module radio_join_uplink_sequencer
  import rjus_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  rjus_item_if.sink    item,
  rjus_result_if.source result,
  rjus_cfg_if.sink     cfg
);

  cfg_t       regs;
  seq_state_t state;
  seq_state_t state_next;
  cmd_t       cmd;

  logic       hold_valid;
  item_t      hold_item;
  logic       res_free;
  logic       advance;

  rjus_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rjus_step u_step (
    .cur  (state),
    .item (hold_item),
    .regs (regs),
    .nxt  (state_next),
    .cmd  (cmd)
  );

  assign res_free   = !result.valid || result.ready;
  assign advance    = hold_valid && res_free;
  assign item.ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      result.valid <= 1'b0;
      state        <= '0;
    end else begin
      if (item.valid && item.ready) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        state        <= state_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      hold_item.func           <= item.func;
      hold_item.now_time       <= item.now_time;
      hold_item.join_ok_flag   <= item.join_ok_flag;
      hold_item.join_fail_flag <= item.join_fail_flag;
      hold_item.tx_ready       <= item.tx_ready;
    end
    if (advance) begin
      result.command      <= cmd;
      result.is_joined    <= state_next.joined_state;
      result.current_step <= state_next.step_number;
      result.active       <= state_next.armed;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rjus_checker.sv =====
// Port-level checks for the sequencer, bound to the top level.
// Depends on rjus_pkg and radio_join_uplink_sequencer.
`default_nettype none

module rjus_checker
  import rjus_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              res_valid,
  input wire logic              res_ready,
  input wire logic [CMD_W-1:0]  command,
  input wire logic              is_joined,
  input wire logic [STEP_W-1:0] current_step,
  input wire logic              active
);

  // Stalled result holds until transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(command) && $stable(is_joined) &&
      $stable(current_step) && $stable(active))
    else $error("result changed while stalled");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    res_valid && !active |-> command == CMD_NONE)
    else $error("command issued while not armed");

  a_uplink_joined: assert property (@(posedge clk) disable iff (rst)
    res_valid && command == CMD_UPLINK |-> is_joined)
    else $error("uplink while not joined");

  a_join_step: assert property (@(posedge clk) disable iff (rst)
    res_valid && command == CMD_JOIN |-> current_step == STEP_DONE && !is_joined)
    else $error("join command with inconsistent status");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> current_step <= STEP_DONE && command <= CMD_UPLINK)
    else $error("step or command out of range");

endmodule

bind radio_join_uplink_sequencer rjus_checker u_rjus_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .command      (result.command),
  .is_joined    (result.is_joined),
  .current_step (result.current_step),
  .active       (result.active)
);

`default_nettype wire
